// ===== hw/rtl/tpoa_pkg.sv =====
package tpoa_pkg;

  // operation codes
  localparam logic [2:0] OP_SET_BASE = 3'd0;
  localparam logic [2:0] OP_PUSH     = 3'd1;
  localparam logic [2:0] OP_REFRESH  = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;
  localparam logic [2:0] OP_RESET    = 3'd5;

  // side codes
  localparam logic [1:0] SIDE_LEFT  = 2'd0;
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_NONE  = 2'd3;

  localparam logic [15:0] MIN_DURATION_MS = 16'd10;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch request fields
    logic scan_init;  // restart slot scan
    logic scan_run;   // scan in progress
    logic scan_sel;   // 1 selection pass, 0 modify pass
    logic apply;      // write entry / decide reselection
    logic emit;       // send selected command
    logic side;       // side being worked on
    logic out_idx;    // result being presented
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic       need_sel;
    logic       enabled;
    logic [1:0] res_cnt;
  } dp_stat_t;

endpackage

// ===== hw/rtl/tpoa_datapath.sv =====
module tpoa_datapath #(
  parameter int SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  tpoa_pkg::dp_cmd_t  cmd,
  output tpoa_pkg::dp_stat_t stat,
  input  logic [2:0]         opcode,
  input  logic [1:0]         side,
  input  logic [63:0]        command,
  input  logic [15:0]        duration_ms,
  input  logic signed [7:0]  priority_req,
  input  logic [7:0]         label_id,
  input  logic [31:0]        now_ms,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               out_side,
  output logic [63:0]        out_command,
  output logic               last
);
  import tpoa_pkg::*;

  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = 2 ** (AW + 1);
  localparam logic [AW:0] SLOTS_C = (AW + 1)'(SLOTS);

  // latched request
  logic [2:0]  op_r;
  logic [63:0] cmd_r;
  logic [7:0]  pri_r;
  logic [7:0]  lbl_r;
  logic [31:0] now_r;
  logic [31:0] exp_r;

  // slot store
  logic [7:0]  mem_label [DEPTH];
  logic [7:0]  mem_pri   [DEPTH];
  logic [31:0] mem_exp   [DEPTH];
  logic [31:0] mem_seq   [DEPTH];
  logic [63:0] mem_cmd   [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]  rd_label, rd_pri;
  logic [31:0] rd_exp, rd_seq;
  logic [63:0] rd_cmd;

  // side state
  logic [63:0] base [2];
  logic [63:0] last_sent [2];
  logic [1:0]  ever_sent;
  logic [31:0] seq_cnt;
  logic        enabled;

  // scan state
  logic [AW:0]   rd_idx;
  logic          ev_valid;
  logic [AW-1:0] ev_idx;
  logic          free_found, hit_found, best_found, removed;
  logic [AW-1:0] free_idx, hit_idx;
  logic [31:0]   hit_seq, best_seq;
  logic [7:0]    best_pri;
  logic [63:0]   best_cmd;

  // results
  logic [1:0]  res_cnt;
  logic        res_side [2];
  logic [63:0] res_cmd  [2];

  logic [AW:0]   raddr, waddr, eaddr;
  logic          ev_slot_valid, lbl_match, expired, better, wr_ok;
  logic [31:0]   exp_diff, best_diff, hit_diff;
  logic [AW-1:0] wr_idx;
  logic [63:0]   sel_cmd;
  logic [15:0]   dur_eff;

  assign dur_eff = (duration_ms < MIN_DURATION_MS) ? MIN_DURATION_MS : duration_ms;
  assign raddr   = {cmd.side, rd_idx[AW-1:0]};
  assign eaddr   = {cmd.side, ev_idx};
  assign ev_slot_valid = valid[eaddr];
  assign lbl_match = rd_label == lbl_r;
  assign exp_diff  = rd_exp - now_r;
  assign expired   = (exp_diff == 32'd0) || exp_diff[31];
  assign best_diff = rd_seq - best_seq;
  assign hit_diff  = hit_seq - rd_seq;
  assign better    = !best_found || ($signed(rd_pri) > $signed(best_pri)) ||
                     ((rd_pri == best_pri) && (best_diff != 32'd0) && !best_diff[31]);
  assign wr_ok     = (op_r == OP_REFRESH && hit_found) || free_found;
  assign wr_idx    = (op_r == OP_REFRESH && hit_found) ? hit_idx : free_idx;
  assign waddr     = {cmd.side, wr_idx};
  assign sel_cmd   = (op_r == OP_RESET) ? 64'd0 : (best_found ? best_cmd : base[cmd.side]);

  // status
  always_comb begin
    stat.scan_done = cmd.scan_run && (rd_idx == SLOTS_C) && !ev_valid;
    stat.enabled   = enabled;
    stat.res_cnt   = res_cnt;
    case (op_r)
      OP_PUSH, OP_REFRESH: stat.need_sel = wr_ok;
      default:             stat.need_sel = removed;
    endcase
  end

  // slot store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.apply && (op_r == OP_PUSH || op_r == OP_REFRESH) && wr_ok) begin
      mem_label[waddr] <= lbl_r;
      mem_pri[waddr]   <= pri_r;
      mem_exp[waddr]   <= exp_r;
      mem_seq[waddr]   <= (op_r == OP_REFRESH && hit_found) ? hit_seq : seq_cnt + 32'd1;
      mem_cmd[waddr]   <= cmd_r;
    end
    rd_label <= mem_label[raddr];
    rd_pri   <= mem_pri[raddr];
    rd_exp   <= mem_exp[raddr];
    rd_seq   <= mem_seq[raddr];
    rd_cmd   <= mem_cmd[raddr];
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      cmd_r <= command;
      pri_r <= priority_req;
      lbl_r <= label_id;
      now_r <= now_ms;
      exp_r <= now_ms + {16'd0, dur_eff};
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      free_found <= 1'b0;
      hit_found  <= 1'b0;
      best_found <= 1'b0;
      removed    <= 1'b0;
    end else if (cmd.scan_run && ev_valid) begin
      if (cmd.scan_sel) begin
        if (ev_slot_valid && better) begin
          best_found <= 1'b1;
          best_pri   <= rd_pri;
          best_seq   <= rd_seq;
          best_cmd   <= rd_cmd;
        end
      end else begin
        if (!ev_slot_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= ev_idx;
        end
        if (op_r == OP_REFRESH && ev_slot_valid && lbl_match &&
            (!hit_found || ((hit_diff != 32'd0) && !hit_diff[31]))) begin
          hit_found <= 1'b1;
          hit_idx   <= ev_idx;
          hit_seq   <= rd_seq;
        end
        if (ev_slot_valid && ((op_r == OP_CLEAR && lbl_match) ||
                              (op_r == OP_TICK && expired))) begin
          removed <= 1'b1;
        end
      end
    end
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      ev_valid <= 1'b0;
    end else if (cmd.scan_init) begin
      rd_idx   <= '0;
      ev_valid <= 1'b0;
    end else if (cmd.scan_run) begin
      if (rd_idx != SLOTS_C) begin
        ev_idx   <= rd_idx[AW-1:0];
        rd_idx   <= rd_idx + 1'b1;
        ev_valid <= 1'b1;
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // valid bits, enable, bases, sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      enabled <= 1'b1;
      base[0] <= '0;
      base[1] <= '0;
      seq_cnt <= '0;
    end else begin
      if (cfg_valid) begin
        enabled <= cfg_data;
        if (!cfg_data) valid <= '0;
      end
      if (cmd.load) begin
        if (opcode == OP_SET_BASE && side != SIDE_NONE) begin
          if (side != SIDE_RIGHT) base[0] <= command;
          if (side != SIDE_LEFT)  base[1] <= command;
        end
        if (opcode == OP_RESET) begin
          valid   <= '0;
          base[0] <= '0;
          base[1] <= '0;
        end
      end
      if (cmd.scan_run && ev_valid && !cmd.scan_sel && ev_slot_valid &&
          ((op_r == OP_CLEAR && lbl_match) || (op_r == OP_TICK && expired))) begin
        valid[eaddr] <= 1'b0;
      end
      if (cmd.apply && (op_r == OP_PUSH || op_r == OP_REFRESH) && wr_ok) begin
        valid[waddr] <= 1'b1;
        if (!(op_r == OP_REFRESH && hit_found)) seq_cnt <= seq_cnt + 32'd1;
      end
    end
  end

  // send with duplicate suppression
  always_ff @(posedge clk) begin
    if (rst) begin
      ever_sent    <= '0;
      last_sent[0] <= '0;
      last_sent[1] <= '0;
      res_cnt      <= '0;
    end else if (cmd.load) begin
      res_cnt <= '0;
    end else if (cmd.emit) begin
      if (!(ever_sent[cmd.side] && last_sent[cmd.side] == sel_cmd) && res_cnt != 2'd2) begin
        last_sent[cmd.side] <= sel_cmd;
        ever_sent[cmd.side] <= 1'b1;
        res_side[res_cnt[0]] <= cmd.side;
        res_cmd[res_cnt[0]]  <= sel_cmd;
        res_cnt <= res_cnt + 2'd1;
      end
    end
  end

  assign out_side    = res_side[cmd.out_idx];
  assign out_command = res_cmd[cmd.out_idx];
  assign last        = ({1'b0, cmd.out_idx} + 2'd1) == res_cnt;

endmodule

// ===== hw/rtl/tpoa_ctrl.sv =====
module tpoa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         opcode,
  input  logic [1:0]         side,
  output tpoa_pkg::dp_cmd_t  cmd,
  input  tpoa_pkg::dp_stat_t stat
);
  import tpoa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_SEL   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_NEXT  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;
  logic       cur_side, cur_side_next;
  logic       hi_side, hi_side_next;
  logic       out_idx, out_idx_next;
  logic [2:0] op_r, op_r_next;
  logic       accept;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_OUT;
  assign accept    = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    cur_side_next = cur_side;
    hi_side_next  = hi_side;
    out_idx_next  = out_idx;
    op_r_next     = op_r;
    cmd           = '0;
    cmd.side      = cur_side;
    cmd.out_idx   = out_idx;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load      = 1'b1;
          op_r_next     = opcode;
          cur_side_next = side == SIDE_RIGHT;
          hi_side_next  = side != SIDE_LEFT;
          case (opcode)
            OP_SET_BASE: begin
              if (side != SIDE_NONE && stat.enabled) begin
                cmd.scan_init = 1'b1;
                state_next    = S_SEL;
              end
            end
            OP_PUSH, OP_REFRESH, OP_CLEAR: begin
              if (side != SIDE_NONE && stat.enabled) begin
                cmd.scan_init = 1'b1;
                state_next    = S_MOD;
              end
            end
            OP_TICK: begin
              cur_side_next = 1'b0;
              hi_side_next  = 1'b1;
              if (stat.enabled) begin
                cmd.scan_init = 1'b1;
                state_next    = S_MOD;
              end
            end
            OP_RESET: begin
              cur_side_next = 1'b0;
              hi_side_next  = 1'b1;
              state_next    = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        if (stat.need_sel) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SEL;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_SEL: begin
        cmd.scan_run = 1'b1;
        cmd.scan_sel = 1'b1;
        if (stat.scan_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (cur_side == hi_side) begin
          out_idx_next = 1'b0;
          state_next   = (stat.res_cnt != 2'd0) ? S_OUT : S_IDLE;
        end else begin
          cur_side_next = 1'b1;
          case (op_r)
            OP_RESET: state_next = S_EMIT;
            OP_SET_BASE: begin
              cmd.scan_init = 1'b1;
              state_next    = S_SEL;
            end
            default: begin
              cmd.scan_init = 1'b1;
              state_next    = S_MOD;
            end
          endcase
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (({1'b0, out_idx} + 2'd1) == stat.res_cnt) state_next = S_IDLE;
          else out_idx_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_side <= 1'b0;
      hi_side  <= 1'b0;
      out_idx  <= 1'b0;
      op_r     <= OP_SET_BASE;
    end else begin
      state    <= state_next;
      cur_side <= cur_side_next;
      hi_side  <= hi_side_next;
      out_idx  <= out_idx_next;
      op_r     <= op_r_next;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request accepted while results pending");
  a_res_bound: assert property (@(posedge clk) disable iff (rst)
    stat.res_cnt != 2'd3) else $error("result count overflow");
  a_out_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> stat.res_cnt != 2'd0) else $error("presenting with no results");
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.scan_done |-> (state == S_MOD || state == S_SEL)) else $error("stray scan done");

endmodule

// ===== hw/rtl/timed_priority_override_arbiter.sv =====
// Steps per addressed side, after the request is accepted: modify pass, apply, selection pass,
// send and step; set base skips modify and apply, a side left unchanged skips selection and send.
// Results then go out one per cycle while out_ready is high; in_ready returns after the last.
// One request at a time. Reset (rst, synchronous): tables empty, bases and last sent
// cleared, enabled set to 1. cfg_ready is always high; writing 0 empties both tables.
module timed_priority_override_arbiter #(
  parameter int SLOTS_PER_SIDE = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        opcode,
  input  logic [1:0]        side,
  input  logic [63:0]       command,
  input  logic [15:0]       duration_ms,
  input  logic signed [7:0] priority_req,
  input  logic [7:0]        label_id,
  input  logic [31:0]       now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_side,
  output logic [63:0]       out_command,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import tpoa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tpoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .opcode    (opcode),
    .side      (side),
    .cmd       (cmd),
    .stat      (stat)
  );

  tpoa_datapath #(.SLOTS(SLOTS_PER_SIDE)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .opcode       (opcode),
    .side         (side),
    .command      (command),
    .duration_ms  (duration_ms),
    .priority_req (priority_req),
    .label_id     (label_id),
    .now_ms       (now_ms),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .out_side     (out_side),
    .out_command  (out_command),
    .last         (last)
  );

endmodule
